// File: rtl/core/rcpc_pkg.sv
package rcpc_pkg;

  localparam int unsigned FractionBitsDefault = 8;
  localparam int unsigned MaxRowsDefault      = 2048;

  localparam int unsigned DistWidth   = 24;
  localparam int unsigned RowWidth    = 11;
  localparam int unsigned TexColWidth = 10;
  localparam int unsigned TexRowWidth = 10;
  localparam int unsigned ColorWidth  = 24;
  localparam int unsigned KindWidth   = 2;

  localparam int unsigned ScaleWidth  = 32;
  localparam int unsigned ScrHWidth   = 12;
  localparam int unsigned TexHWidth   = 11;
  localparam int unsigned WallWidth   = 32;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgWidth    = 32;

  localparam logic [ScaleWidth-1:0] ScaleReset   = 32'd14529280;
  localparam logic [ScrHWidth-1:0]  ScrHReset    = 12'd512;
  localparam logic [TexHWidth-1:0]  TexHReset    = 11'd64;
  localparam logic [ColorWidth-1:0] CeilColReset = 24'd0;
  localparam logic [ColorWidth-1:0] FlrColReset  = 24'd8421504;

  typedef enum logic [KindWidth-1:0] {
    KindCeiling = 2'd0,
    KindWall    = 2'd1,
    KindFloor   = 2'd2,
    KindOutside = 2'd3
  } pixel_kind_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegProjScale = 3'd0,
    RegScrHeight = 3'd1,
    RegTexHeight = 3'd2,
    RegCeilColor = 3'd3,
    RegFlrColor  = 3'd4
  } cfg_reg_e;

endpackage

// File: rtl/core/rcpc_in_if.sv
interface rcpc_in_if;
  logic                              valid;
  logic                              ready;
  logic [rcpc_pkg::DistWidth-1:0]    ray_distance;
  logic [rcpc_pkg::RowWidth-1:0]     screen_row;
  logic [rcpc_pkg::TexColWidth-1:0]  texture_column;

  modport source (output valid, ray_distance, screen_row, texture_column, input ready);
  modport sink   (input valid, ray_distance, screen_row, texture_column, output ready);
endinterface

// File: rtl/core/rcpc_out_if.sv
interface rcpc_out_if;
  logic                              valid;
  logic                              ready;
  logic [rcpc_pkg::KindWidth-1:0]    pixel_kind;
  logic [rcpc_pkg::TexRowWidth-1:0]  texture_row;
  logic [rcpc_pkg::TexColWidth-1:0]  texel_column;
  logic [rcpc_pkg::ColorWidth-1:0]   flat_color;

  modport source (output valid, pixel_kind, texture_row, texel_column, flat_color,
                  input ready);
  modport sink   (input valid, pixel_kind, texture_row, texel_column, flat_color,
                  output ready);
endinterface

// File: rtl/core/raycast_column_pixel_classifier.sv
// Pipeline: 32 wall-height divider cells, two classify/multiply stages, 11
// texture-row divider cells and an output register.
// Throughput: one request per cycle; the whole chain advances whenever the output
// register is empty or being taken, so a stalled result holds every stage.
// Reset: rst_ni clears valid flags and loads the register defaults.
module raycast_column_pixel_classifier #(
  parameter int unsigned FRACTION_BITS = rcpc_pkg::FractionBitsDefault,
  parameter int unsigned MAX_ROWS      = rcpc_pkg::MaxRowsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rcpc_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [rcpc_pkg::CfgWidth-1:0]       cfg_data_i,
  rcpc_in_if.sink                             req_i,
  rcpc_out_if.source                          res_o
);

  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned DW  = rcpc_pkg::DistWidth;
  localparam int unsigned WW  = rcpc_pkg::WallWidth;
  localparam int unsigned THW = rcpc_pkg::TexHWidth;
  localparam int unsigned PRW = WW + THW;
  localparam int unsigned SW  = WW + 3;

  typedef struct packed {
    logic                               sat;
    logic [rcpc_pkg::RowWidth-1:0]      row;
    logic [rcpc_pkg::TexColWidth-1:0]   tcol;
  } p1_t;

  typedef struct packed {
    rcpc_pkg::pixel_kind_e              kind;
    logic [rcpc_pkg::TexColWidth-1:0]   tcol;
  } p2_t;

  logic [rcpc_pkg::ScaleWidth-1:0] scale_q;
  logic [rcpc_pkg::ScrHWidth-1:0]  scrh_q;
  logic [THW-1:0]                  texh_q;
  logic [rcpc_pkg::ColorWidth-1:0] ceil_q;
  logic [rcpc_pkg::ColorWidth-1:0] flr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= rcpc_pkg::ScaleReset;
      scrh_q  <= rcpc_pkg::ScrHReset;
      texh_q  <= rcpc_pkg::TexHReset;
      ceil_q  <= rcpc_pkg::CeilColReset;
      flr_q   <= rcpc_pkg::FlrColReset;
    end else if (cfg_we_i) begin
      case (rcpc_pkg::cfg_reg_e'(cfg_idx_i))
        rcpc_pkg::RegProjScale: scale_q <= cfg_data_i;
        rcpc_pkg::RegScrHeight: scrh_q  <= cfg_data_i[rcpc_pkg::ScrHWidth-1:0];
        rcpc_pkg::RegTexHeight: texh_q  <= cfg_data_i[THW-1:0];
        rcpc_pkg::RegCeilColor: ceil_q  <= cfg_data_i[rcpc_pkg::ColorWidth-1:0];
        rcpc_pkg::RegFlrColor:  flr_q   <= cfg_data_i[rcpc_pkg::ColorWidth-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;

  assign en          = !out_valid_q || res_o.ready;
  assign req_i.ready = en;

  // Wall height divider: (scale << F) / distance, 32 quotient bits
  logic          v1   [0:WW];
  logic [DW-1:0] r1   [0:WW];
  logic [WW-1:0] l1   [0:WW];
  logic [DW-1:0] d1   [0:WW];
  p1_t           p1   [0:WW];

  always_comb begin
    v1[0]      = req_i.valid;
    r1[0]      = DW'(scale_q[WW-1:WW-F]);
    l1[0]      = {scale_q[WW-F-1:0], {F{1'b0}}};
    d1[0]      = req_i.ray_distance;
    p1[0].sat  = (DW'(scale_q[WW-1:WW-F]) >= req_i.ray_distance);
    p1[0].row  = req_i.screen_row;
    p1[0].tcol = req_i.texture_column;
  end

  for (genvar g = 0; g < WW; g++) begin : g_wall
    rcpc_div_cell #(.W(DW), .QW(WW), .PW($bits(p1_t))) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v1[g]),
      .rem_i   (r1[g]),
      .lo_i    (l1[g]),
      .div_i   (d1[g]),
      .pay_i   (p1[g]),
      .valid_o (v1[g+1]),
      .rem_o   (r1[g+1]),
      .lo_o    (l1[g+1]),
      .div_o   (d1[g+1]),
      .pay_o   (p1[g+1])
    );
  end

  // Classify
  logic [WW-1:0]           wall_b;
  logic signed [SW-1:0]    top_b;
  logic signed [SW-1:0]    rowfx_b;
  logic signed [SW-1:0]    bot_b;
  logic signed [SW-1:0]    off_b;
  logic                    outside_b;
  rcpc_pkg::pixel_kind_e   kind_b;

  always_comb begin
    wall_b    = p1[WW].sat ? {WW{1'b1}} : l1[WW];
    top_b     = $signed(SW'(scrh_q[rcpc_pkg::ScrHWidth-1:1]) << F)
              - $signed(SW'(wall_b >> 1));
    rowfx_b   = $signed(SW'(p1[WW].row) << F);
    bot_b     = top_b + $signed(SW'(wall_b));
    off_b     = rowfx_b - top_b;
    outside_b = (rcpc_pkg::ScrHWidth'(p1[WW].row) >= scrh_q)
             || (32'(p1[WW].row) >= 32'(MAX_ROWS));
    if (outside_b) begin
      kind_b = rcpc_pkg::KindOutside;
    end else if (rowfx_b < top_b) begin
      kind_b = rcpc_pkg::KindCeiling;
    end else if (rowfx_b < bot_b) begin
      kind_b = rcpc_pkg::KindWall;
    end else begin
      kind_b = rcpc_pkg::KindFloor;
    end
  end

  logic        vb_q;
  p2_t         pb_q;
  logic [WW-1:0] offb_q;
  logic [WW-1:0] wallb_q;

  logic        vc_q;
  p2_t         pc_q;
  logic [PRW-1:0] prod_q;
  logic [WW-1:0]  wallc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      vb_q <= v1[WW];
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pb_q.kind <= kind_b;
      pb_q.tcol <= p1[WW].tcol;
      offb_q    <= off_b[WW-1:0];
      wallb_q   <= wall_b;
      pc_q      <= pb_q;
      prod_q    <= PRW'(offb_q) * PRW'(texh_q);
      wallc_q   <= wallb_q;
    end
  end

  // Texture row divider: (offset * texture height) / wall height
  logic          v2 [0:THW];
  logic [WW-1:0] r2 [0:THW];
  logic [THW-1:0] l2 [0:THW];
  logic [WW-1:0] d2 [0:THW];
  p2_t           p2 [0:THW];

  always_comb begin
    v2[0] = vc_q;
    r2[0] = prod_q[PRW-1:THW];
    l2[0] = prod_q[THW-1:0];
    d2[0] = wallc_q;
    p2[0] = pc_q;
  end

  for (genvar g = 0; g < THW; g++) begin : g_tex
    rcpc_div_cell #(.W(WW), .QW(THW), .PW($bits(p2_t))) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v2[g]),
      .rem_i   (r2[g]),
      .lo_i    (l2[g]),
      .div_i   (d2[g]),
      .pay_i   (p2[g]),
      .valid_o (v2[g+1]),
      .rem_o   (r2[g+1]),
      .lo_o    (l2[g+1]),
      .div_o   (d2[g+1]),
      .pay_o   (p2[g+1])
    );
  end

  // Clamp and pack
  logic [THW-1:0] lim;
  logic [THW-1:0] trc;
  logic [rcpc_pkg::TexRowWidth-1:0] tr_d;
  logic [rcpc_pkg::KindWidth-1:0]   kind_q;
  logic [rcpc_pkg::TexRowWidth-1:0] trow_q;
  logic [rcpc_pkg::TexColWidth-1:0] tcol_q;
  logic [rcpc_pkg::ColorWidth-1:0]  col_q;

  always_comb begin
    lim = texh_q - THW'(1);
    trc = (l2[THW] > lim) ? lim : l2[THW];
    if (texh_q == '0) begin
      tr_d = '0;
    end else if (trc > THW'(1023)) begin
      tr_d = rcpc_pkg::TexRowWidth'(1023);
    end else begin
      tr_d = trc[rcpc_pkg::TexRowWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v2[THW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q <= p2[THW].kind;
      trow_q <= '0;
      tcol_q <= '0;
      col_q  <= '0;
      case (p2[THW].kind)
        rcpc_pkg::KindCeiling: col_q <= ceil_q;
        rcpc_pkg::KindFloor:   col_q <= flr_q;
        rcpc_pkg::KindWall: begin
          trow_q <= tr_d;
          tcol_q <= p2[THW].tcol;
        end
        default: ;
      endcase
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.pixel_kind   = kind_q;
  assign res_o.texture_row  = trow_q;
  assign res_o.texel_column = tcol_q;
  assign res_o.flat_color   = col_q;

endmodule

// File: rtl/core/rcpc_div_cell.sv
module rcpc_div_cell #(
  parameter int unsigned W  = 24,
  parameter int unsigned QW = 32,
  parameter int unsigned PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [W-1:0]  rem_i,
  input  logic [QW-1:0] lo_i,
  input  logic [W-1:0]  div_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [W-1:0]  rem_o,
  output logic [QW-1:0] lo_o,
  output logic [W-1:0]  div_o,
  output logic [PW-1:0] pay_o
);

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          ge;
  logic [W-1:0]  rem_d;
  logic [QW-1:0] lo_d;

  always_comb begin
    trial = {rem_i, lo_i[QW-1]};
    diff  = trial - {1'b0, div_i};
    ge    = trial >= {1'b0, div_i};
    rem_d = ge ? diff[W-1:0] : trial[W-1:0];
    lo_d  = {lo_i[QW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      lo_o  <= lo_d;
      div_o <= div_i;
      pay_o <= pay_i;
    end
  end

endmodule
